/* design/system_bus_address_decoder_defines.svh */
// Assertion macros used by the system bus address decoder top level.
`ifndef SYSTEM_BUS_ADDRESS_DECODER_DEFINES_SVH
`define SYSTEM_BUS_ADDRESS_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge outside reset.
`define SBAD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Consequence that must hold in the same cycle as the antecedent.
`define SBAD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequence that must hold in the cycle after the antecedent.
`define SBAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SBAD_ASSERT_ALWAYS(lbl, cond)
`define SBAD_ASSERT_IMPLY(lbl, ante, cons)
`define SBAD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* design/sbad_pkg.sv */
// Types, region constants and codes for the system bus address decoder.
package sbad_pkg;

  // Sizes of the memory regions and of the peripheral slot space.
  localparam int unsigned BOOTROM_WORDS = 4096;
  localparam int unsigned FLASH_BYTES   = 16777216;
  localparam int unsigned SRAM_BYTES    = 270336;
  localparam int unsigned DPRAM_BYTES   = 4096;
  localparam int unsigned PERIPH_SLOTS  = 82113;

  localparam logic [32:0] BOOT_LIMIT = 33'(BOOTROM_WORDS) * 33'd4;
  localparam logic [32:0] FLASH_SIZE = 33'(FLASH_BYTES);
  localparam logic [32:0] SRAM_SIZE  = 33'(SRAM_BYTES);
  localparam logic [32:0] DPRAM_SIZE = 33'(DPRAM_BYTES);
  localparam logic [18:0] SLOT_LIMIT = 19'(PERIPH_SLOTS);

  // Region bases and masks.
  localparam logic [31:0] FLASH_BASE       = 32'h1000_0000;
  localparam logic [31:0] FLASH_MIRROR_END = 32'h1400_0000;
  localparam logic [31:0] FLASH_MIRROR_MSK = 32'h00ff_ffff;
  localparam logic [31:0] SRAM_BASE        = 32'h2000_0000;
  localparam logic [31:0] DPRAM_BASE       = 32'h5010_0000;
  localparam logic [3:0]  SIO_TOP_NIBBLE   = 4'hd;
  localparam logic [19:0] PPB_PAGE         = 20'he000e;
  localparam logic [31:0] ALL_ONES         = 32'hffff_ffff;

  // Access modes and sizes.
  localparam logic       MODE_READ  = 1'b0;
  localparam logic [1:0] SZ_BYTE    = 2'd0;
  localparam logic [1:0] SZ_HALF    = 2'd1;
  localparam logic [1:0] SZ_WORD    = 2'd2;
  localparam logic [1:0] SZ_RSVD    = 2'd3;

  // Target codes.
  localparam logic [2:0] TGT_BOOT   = 3'd0;
  localparam logic [2:0] TGT_FLASH  = 3'd1;
  localparam logic [2:0] TGT_SRAM   = 3'd2;
  localparam logic [2:0] TGT_DPRAM  = 3'd3;
  localparam logic [2:0] TGT_PPB    = 3'd4;
  localparam logic [2:0] TGT_SIO    = 3'd5;
  localparam logic [2:0] TGT_PERIPH = 3'd6;
  localparam logic [2:0] TGT_NONE   = 3'd7;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISALIGN = 2'd1;
  localparam logic [1:0] ST_OOB      = 2'd2;
  localparam logic [1:0] ST_UNMAPPED = 2'd3;

  // Peripheral slots that have a device behind them.
  localparam int POP_COUNT = 32;
  localparam logic [17:0] POP_SLOTS [POP_COUNT] = '{
    18'h06000,
    18'h10000, 18'h10001, 18'h10002, 18'h10003, 18'h10004, 18'h10005, 18'h10006,
    18'h10007, 18'h10008, 18'h10009, 18'h1000a, 18'h1000b, 18'h1000c, 18'h1000d,
    18'h1000e, 18'h1000f, 18'h10010, 18'h10011, 18'h10012, 18'h10013, 18'h10014,
    18'h10015, 18'h10016, 18'h10017, 18'h10018, 18'h10019, 18'h1001b,
    18'h14000, 18'h14044, 18'h14080, 18'h140c0
  };

  // One bus access.
  typedef struct packed {
    logic        mode;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_data;
  } sbad_in_t;

  // Decoded access.
  typedef struct packed {
    logic [2:0]  target;
    logic [27:0] local_offset;
    logic [16:0] peripheral_slot;
    logic [1:0]  atomic_type;
    logic [31:0] bus_data;
    logic [3:0]  byte_enable;
    logic        rmw_needed;
    logic        notify_usb;
    logic [1:0]  status;
  } sbad_out_t;

endpackage

/* design/sbad_decode.sv */
// Combinational decode of one registered bus access into its result item.
module sbad_decode
  import sbad_pkg::*;
(
  input  sbad_in_t  item_i,
  output sbad_out_t result_o
);

  // Intermediate decode of one region lookup.
  typedef struct packed {
    logic [2:0]  tgt;
    logic [31:0] off;
    logic [16:0] slot;
    logic [1:0]  atom;
    logic [1:0]  st;
    logic        notify;
  } dec_t;

  function automatic dec_t mk(logic [2:0] tgt, logic [31:0] off, logic [1:0] st);
    dec_t d;
    d.tgt    = tgt;
    d.off    = off;
    d.slot   = '0;
    d.atom   = '0;
    d.st     = st;
    d.notify = 1'b0;
    return d;
  endfunction

  function automatic logic in_rgn(logic [31:0] a, logic [31:0] base, logic [32:0] size);
    logic [31:0] diff;
    diff = a - base;
    return (a >= base) && ({1'b0, diff} < size);
  endfunction

  // Out of bounds when an n-byte access at off runs past the region end.
  function automatic logic [1:0] sized(logic [31:0] off, logic [2:0] n, logic [32:0] size);
    return (({1'b0, off} + 33'(n)) > size) ? ST_OOB : ST_OK;
  endfunction

  function automatic logic slot_pop(logic [31:0] a);
    logic [17:0] s;
    logic        hit;
    s   = a[31:14];
    hit = 1'b0;
    for (int i = 0; i < POP_COUNT; i++) begin
      if (POP_SLOTS[i] == s) begin
        hit = 1'b1;
      end
    end
    return hit && ({1'b0, s} < SLOT_LIMIT);
  endfunction

  // Word read lookup order.
  function automatic dec_t read_word(logic [31:0] a, logic pop);
    dec_t        d;
    logic [31:0] off;
    d = mk(TGT_NONE, '0, ST_UNMAPPED);
    if ({1'b0, a} < BOOT_LIMIT) begin
      d = mk(TGT_BOOT, a, ST_OK);
    end else if (a >= FLASH_BASE && a < FLASH_MIRROR_END) begin
      off = a & FLASH_MIRROR_MSK;
      d = mk(TGT_FLASH, off, sized(off, 3'd4, FLASH_SIZE));
    end else if (in_rgn(a, SRAM_BASE, SRAM_SIZE)) begin
      off = a - SRAM_BASE;
      d = mk(TGT_SRAM, off, sized(off, 3'd4, SRAM_SIZE));
    end else if (in_rgn(a, DPRAM_BASE, DPRAM_SIZE)) begin
      off = a - DPRAM_BASE;
      d = mk(TGT_DPRAM, off, sized(off, 3'd4, DPRAM_SIZE));
    end else if (a[31:12] == PPB_PAGE) begin
      d = mk(TGT_PPB, {20'd0, a[11:0]}, ST_OK);
    end else if (a[31:28] == SIO_TOP_NIBBLE) begin
      d = mk(TGT_SIO, {4'd0, a[27:0]}, ST_OK);
    end else if (pop) begin
      d = mk(TGT_PERIPH, {18'd0, a[13:0]}, ST_OK);
      d.slot = a[30:14];
    end
    return d;
  endfunction

  // Word write lookup order.
  function automatic dec_t write_word(logic [31:0] a, logic pop);
    dec_t        d;
    logic [31:0] off;
    d = mk(TGT_NONE, '0, ST_UNMAPPED);
    if (pop) begin
      d = mk(TGT_PERIPH, {20'd0, a[11:0]}, ST_OK);
      d.slot = a[30:14];
      d.atom = a[13:12];
    end else if ({1'b0, a} < BOOT_LIMIT) begin
      d = mk(TGT_BOOT, a, ST_OK);
    end else if (in_rgn(a, FLASH_BASE, FLASH_SIZE)) begin
      off = a - FLASH_BASE;
      d = mk(TGT_FLASH, off, sized(off, 3'd4, FLASH_SIZE));
    end else if (in_rgn(a, SRAM_BASE, SRAM_SIZE)) begin
      off = a - SRAM_BASE;
      d = mk(TGT_SRAM, off, sized(off, 3'd4, SRAM_SIZE));
    end else if (in_rgn(a, DPRAM_BASE, DPRAM_SIZE)) begin
      off = a - DPRAM_BASE;
      d = mk(TGT_DPRAM, off, sized(off, 3'd4, DPRAM_SIZE));
      d.notify = (d.st == ST_OK);
    end else if (a[31:28] == SIO_TOP_NIBBLE) begin
      d = mk(TGT_SIO, {4'd0, a[27:0]}, ST_OK);
    end else if (a[31:12] == PPB_PAGE) begin
      d = mk(TGT_PPB, {20'd0, a[11:0]}, ST_OK);
    end
    return d;
  endfunction

  // Halfword read: flash and SRAM directly, else the aligned word lookup.
  function automatic dec_t read_half(logic [31:0] a, dec_t word_dec);
    dec_t d;
    d = word_dec;
    if (in_rgn(a, FLASH_BASE, FLASH_SIZE)) begin
      d = mk(TGT_FLASH, a - FLASH_BASE, sized(a - FLASH_BASE, 3'd2, FLASH_SIZE));
    end else if (in_rgn(a, SRAM_BASE, SRAM_SIZE)) begin
      d = mk(TGT_SRAM, a - SRAM_BASE, sized(a - SRAM_BASE, 3'd2, SRAM_SIZE));
    end
    return d;
  endfunction

  logic [31:0] addr;
  logic [31:0] aligned;
  logic [1:0]  lane;
  logic [1:0]  sz;
  logic        pop;
  logic        is_byte;
  dec_t        rd_word;
  dec_t        wr_word;
  dec_t        d;
  logic [3:0]  be;
  logic [31:0] data;
  logic        rmw;

  // Both word lookups, on the word address or the aligned address, feed the selection below.
  always_comb begin
    addr    = item_i.address;
    aligned = {addr[31:2], 2'b00};
    lane    = addr[1:0];
    sz      = (item_i.access_size == SZ_RSVD) ? SZ_WORD : item_i.access_size;
    is_byte = (sz == SZ_BYTE);
    pop     = slot_pop(addr);
    rd_word = read_word((item_i.mode == MODE_READ && sz == SZ_WORD) ? addr : aligned, pop);
    wr_word = write_word((sz == SZ_WORD) ? addr : aligned, pop);
  end

  // Select the decode for the access kind and form lanes and data.
  always_comb begin
    d    = rd_word;
    be   = 4'hf;
    data = '0;
    rmw  = 1'b0;
    if (item_i.mode == MODE_READ) begin
      case (sz)
        SZ_BYTE: begin
          be = 4'(4'b0001 << lane);
          if (in_rgn(addr, FLASH_BASE, FLASH_SIZE)) begin
            d = mk(TGT_FLASH, addr - FLASH_BASE, ST_OK);
          end else if (in_rgn(addr, SRAM_BASE, SRAM_SIZE)) begin
            d = mk(TGT_SRAM, addr - SRAM_BASE, ST_OK);
          end else begin
            d = read_half({addr[31:1], 1'b0}, rd_word);
          end
        end
        SZ_HALF: begin
          if (in_rgn(addr, FLASH_BASE, FLASH_SIZE) || in_rgn(addr, SRAM_BASE, SRAM_SIZE)) begin
            be = 4'(4'b0011 << lane);
          end else begin
            be = addr[1] ? 4'b1100 : 4'b0011;
          end
          d = read_half(addr, rd_word);
        end
        default: begin
          d = rd_word;
          if (d.st == ST_OK && lane != 2'd0) begin
            d.st = ST_MISALIGN;
          end
        end
      endcase
      data = (d.st == ST_UNMAPPED) ? ALL_ONES : '0;
    end else if (sz == SZ_WORD) begin
      d    = wr_word;
      data = item_i.write_data;
      if (d.tgt == TGT_BOOT && lane != 2'd0) begin
        be = 4'h0;
      end
    end else begin
      be   = is_byte ? 4'(4'b0001 << lane) : 4'(4'b0011 << lane);
      data = item_i.write_data;
      if (in_rgn(addr, SRAM_BASE, SRAM_SIZE)) begin
        d = mk(TGT_SRAM, addr - SRAM_BASE,
               is_byte ? ST_OK : sized(addr - SRAM_BASE, 3'd2, SRAM_SIZE));
      end else if (pop) begin
        // Peripherals take sub-word writes as replicated word writes.
        d      = mk(TGT_PERIPH, {20'd0, aligned[11:0]}, ST_OK);
        d.slot = addr[30:14];
        d.atom = aligned[13:12];
        data   = is_byte ? {4{item_i.write_data[7:0]}} : {2{item_i.write_data[15:0]}};
      end else begin
        // Read-modify-write of the aligned word.
        rmw = 1'b1;
        d   = wr_word;
        if (rd_word.st == ST_OOB || (!is_byte && lane == 2'd3)) begin
          d.st     = ST_OOB;
          d.notify = 1'b0;
        end
      end
    end
    if (d.st == ST_OOB || d.st == ST_UNMAPPED) begin
      be       = 4'h0;
      d.notify = 1'b0;
    end
  end

  assign result_o.target          = d.tgt;
  assign result_o.local_offset    = d.off[27:0];
  assign result_o.peripheral_slot = d.slot;
  assign result_o.atomic_type     = d.atom;
  assign result_o.bus_data        = data;
  assign result_o.byte_enable     = be;
  assign result_o.rmw_needed      = rmw;
  assign result_o.notify_usb      = d.notify;
  assign result_o.status          = d.st;

endmodule

/* design/system_bus_address_decoder.sv */
// Top level of the system bus address decoder: input register, decode, result register.

// Decodes one bus access per clock, while the output is not stalled, into its target
// region, local offset, peripheral slot and alias, lane data, byte enables and status.
// Throughput is one item every cycle while out_stall is low; each access passes through
// the input register that holds it and the result register that holds the decode. Both
// channels use valid and stall, and a full result register that is stalled lets one more
// item wait in the input register before in_stall rises.
`include "system_bus_address_decoder_defines.svh"

module system_bus_address_decoder
  import sbad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sbad_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output sbad_out_t out_data
);

  logic      in_v_r;
  logic      in_v_nxt;
  sbad_in_t  in_item_r;
  logic      out_v_r;
  logic      out_v_nxt;
  sbad_out_t out_item_r;
  sbad_out_t dec_result;
  logic      out_free;
  logic      in_take;
  logic      in_move;

  // Handshake control for the two register stages.
  always_comb begin
    out_free = !out_v_r || !out_stall;
    in_move  = in_v_r && out_free;
    in_stall = in_v_r && !out_free;
    in_take  = in_valid && !in_stall;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (in_move) begin
      in_v_nxt = 1'b0;
    end else begin
      in_v_nxt = in_v_r;
    end
    out_v_nxt = out_free ? in_v_r : out_v_r;
  end

  // Decode of the held access.
  sbad_decode u_decode (
    .item_i   (in_item_r),
    .result_o (dec_result)
  );

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (in_move) begin
      out_item_r <= dec_result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

  // The input stage only holds back while the result stage is full and stalled.
  `SBAD_ASSERT_IMPLY(a_stall_only_when_full, in_stall, in_v_r && out_v_r && out_stall)
  // An accepted item always lands in the input register.
  `SBAD_ASSERT_NEXT(a_take_fills_input, in_valid && !in_stall, in_v_r)
  // Refused accesses touch no lanes and never notify the USB controller.
  `SBAD_ASSERT_IMPLY(a_refused_quiet,
    out_v_r && (out_item_r.status == ST_OOB || out_item_r.status == ST_UNMAPPED),
    out_item_r.byte_enable == 4'h0 && !out_item_r.notify_usb)
  // A USB notification comes only from a clean DPRAM access.
  `SBAD_ASSERT_IMPLY(a_notify_dpram, out_v_r && out_item_r.notify_usb,
    out_item_r.target == TGT_DPRAM && out_item_r.status == ST_OK)
  // Unmapped accesses decode to no target.
  `SBAD_ASSERT_ALWAYS(a_unmapped_none,
    !out_v_r || out_item_r.status != ST_UNMAPPED || out_item_r.target == TGT_NONE)

endmodule
